// File: rtl/core/tach_pkg.sv
`default_nettype none
package tach_pkg;

    localparam int CAPTURE_BITS = 32;
    localparam int NUM_CHANNELS = 2;
    localparam int CHAN_BITS    = 1;
    localparam int CLK_HZ_BITS  = 27;
    localparam int PPR_BITS     = 5;
    localparam int RPM_BITS     = 33;
    localparam int DIVISOR_BITS = CAPTURE_BITS + PPR_BITS;
    localparam int DIV_STEPS    = RPM_BITS;
    localparam int STEP_BITS    = $clog2(DIV_STEPS);

    localparam int IN_FIELD_BITS  = CHAN_BITS + CAPTURE_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = CHAN_BITS + CAPTURE_BITS + RPM_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = CLK_HZ_BITS;

    localparam logic [CFG_ADDR_BITS-1:0] REG_CLOCK_HZ = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PPR      = 1'b1;

    localparam logic [CLK_HZ_BITS-1:0] CLOCK_HZ_RESET = 27'd16000000;
    localparam logic [PPR_BITS-1:0]    PPR_RESET      = 5'd1;

    typedef struct packed {
        logic capture;   // take an input word, form the period
        logic setup;     // form dividend and divisor, clear the divider
        logic div_step;  // one quotient bit
        logic load_out;  // move the finished result to the output register
    } tach_cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/tach_ctrl.sv
`default_nettype none
module tach_ctrl (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire              m_tready,
    output tach_pkg::tach_cmd_t cmd
);
    import tach_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// File: rtl/core/tach_dp.sv
`default_nettype none
module tach_dp (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire tach_pkg::tach_cmd_t            cmd,
    input  wire                                 cfg_we,
    input  wire [tach_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire [tach_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  wire [tach_pkg::CHAN_BITS-1:0]       in_channel,
    input  wire [tach_pkg::CAPTURE_BITS-1:0]    in_capture_time,
    output logic [tach_pkg::CHAN_BITS-1:0]      out_channel,
    output logic [tach_pkg::CAPTURE_BITS-1:0]   out_period_ticks,
    output logic [tach_pkg::RPM_BITS-1:0]       out_rpm
);
    import tach_pkg::*;

    logic [CLK_HZ_BITS-1:0]  clock_hz_reg;
    logic [PPR_BITS-1:0]     ppr_reg;
    logic [CAPTURE_BITS-1:0] last_capture_reg [NUM_CHANNELS];

    logic [CHAN_BITS-1:0]    chan_reg;
    logic [CAPTURE_BITS-1:0] period_reg;
    logic [DIVISOR_BITS-1:0] divisor_reg;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [RPM_BITS-1:0]     quo_reg, quo_next;
    logic                    div_zero_reg;

    logic [CHAN_BITS-1:0]    res_chan_reg;
    logic [CAPTURE_BITS-1:0] res_period_reg;
    logic [RPM_BITS-1:0]     res_rpm_reg;

    logic [RPM_BITS-1:0]     dividend;
    logic [DIVISOR_BITS-1:0] divisor;
    logic [DIVISOR_BITS:0]   rem_shift;
    logic [DIVISOR_BITS+1:0] trial;
    logic                    fits;

    // 60 * clock_hz as (x << 6) - (x << 2)
    assign dividend = (RPM_BITS'(clock_hz_reg) << 6) - (RPM_BITS'(clock_hz_reg) << 2);
    assign divisor  = DIVISOR_BITS'(period_reg) * DIVISOR_BITS'(ppr_reg);

    // restoring division, quotient bits shift in behind the dividend
    assign rem_shift = {rem_reg, quo_reg[RPM_BITS-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};
    assign fits      = !trial[DIVISOR_BITS+1];

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.setup) begin
            rem_next = '0;
            quo_next = dividend;
        end else if (cmd.div_step) begin
            rem_next = fits ? trial[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[RPM_BITS-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            ppr_reg      <= PPR_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                last_capture_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_CLOCK_HZ: clock_hz_reg <= cfg_wdata;
                    REG_PPR:      ppr_reg      <= cfg_wdata[PPR_BITS-1:0];
                    default: ;
                endcase
            end
            if (cmd.capture) begin
                last_capture_reg[in_channel] <= in_capture_time;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            chan_reg   <= in_channel;
            period_reg <= in_capture_time - last_capture_reg[in_channel];
        end
        if (cmd.setup) begin
            divisor_reg  <= divisor;
            div_zero_reg <= (divisor == '0);
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_out) begin
            res_chan_reg   <= chan_reg;
            res_period_reg <= period_reg;
            res_rpm_reg    <= div_zero_reg ? '0 : quo_reg;
        end
    end

    assign out_channel      = res_chan_reg;
    assign out_period_ticks = res_period_reg;
    assign out_rpm          = res_rpm_reg;

endmodule
`default_nettype wire

// File: rtl/core/tachometer_period_to_rpm.sv
`default_nettype none
// Tachometer period to rpm. Each input word is a timer capture of a tachometer
// edge on channel 0 or 1; the block subtracts the previous capture of that
// channel (zero after reset, modulo 2^32) and returns the period together with
// rpm = 60 * clock_hz / (period * edges per revolution), truncated, or zero when
// the divisor is zero. One item is in work at a time: an item passes the accepting
// cycle, a setup step, the bit-serial restoring divider and a load into the output
// register; the load waits while the previous result has not been taken, and the
// next word can be taken in the cycle after the load. The output register lets a
// new word enter while the previous result waits. Write the tick rate and
// edges-per-revolution registers only while the block is idle.
module tachometer_period_to_rpm (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [tach_pkg::IN_DATA_BITS-1:0]     s_tdata,   // channel, capture_time
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [tach_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // out_channel, period_ticks, rpm
    input  wire                                  cfg_we,
    input  wire [tach_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  wire [tach_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import tach_pkg::*;

    tach_cmd_t               cmd;
    logic [CHAN_BITS-1:0]    out_channel;
    logic [CAPTURE_BITS-1:0] out_period_ticks;
    logic [RPM_BITS-1:0]     out_rpm;

    tach_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tach_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_channel       (s_tdata[CHAN_BITS-1:0]),
        .in_capture_time  (s_tdata[CHAN_BITS +: CAPTURE_BITS]),
        .out_channel      (out_channel),
        .out_period_ticks (out_period_ticks),
        .out_rpm          (out_rpm)
    );

    assign m_tdata = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                      out_rpm, out_period_ticks, out_channel};

endmodule
`default_nettype wire

// File: tb/tb_tachometer_period_to_rpm.sv
`default_nettype none
module tb_tachometer_period_to_rpm;
    import tach_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 40;
    localparam int PHASE_WORDS  = 215;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [RPM_BITS-1:0]     rpm;
        logic [CAPTURE_BITS-1:0] period;
        logic [CHAN_BITS-1:0]    chan;
    } tach_result_t;

    class rpm_scoreboard;
        logic [CLK_HZ_BITS-1:0]  clock_hz;
        logic [PPR_BITS-1:0]     ppr;
        logic [CAPTURE_BITS-1:0] last_cap [NUM_CHANNELS];
        tach_result_t            rpm_q [$];
        int                      mismatches;
        int                      results_seen;

        function new();
            clock_hz     = CLOCK_HZ_RESET;
            ppr          = PPR_RESET;
            last_cap     = '{default: '0};
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_BITS-1:0] addr,
                                logic [CFG_DATA_BITS-1:0] data);
            if (addr == REG_CLOCK_HZ) begin
                clock_hz = data;
            end else if (addr == REG_PPR) begin
                ppr = data[PPR_BITS-1:0];
            end
        endfunction

        // predict the period and rpm for one captured edge
        function void note_capture(logic [CHAN_BITS-1:0] ch,
                                   logic [CAPTURE_BITS-1:0] cap);
            tach_result_t            r;
            logic [DIVISOR_BITS-1:0] divisor;
            logic [RPM_BITS-1:0]     dividend;
            r.chan   = ch;
            r.period = cap - last_cap[ch];
            divisor  = r.period * ppr;
            dividend = 33'd60 * clock_hz;
            r.rpm    = (divisor == '0) ? '0 : RPM_BITS'(dividend / divisor);
            last_cap[ch] = cap;
            rpm_q.push_back(r);
        endfunction

        function void check_result(logic [OUT_DATA_BITS-1:0] word);
            tach_result_t got;
            tach_result_t want;
            got = word[OUT_FIELD_BITS-1:0];
            results_seen++;
            if (rpm_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: channel %0d period %0d rpm %0d",
                             got.chan, got.period, got.rpm);
                return;
            end
            want = rpm_q.pop_front();
            if (got.chan !== want.chan || got.period !== want.period ||
                got.rpm !== want.rpm) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch on result %0d: channel %0d/%0d period %0d/%0d ",
                              "rpm %0d/%0d (expected/actual)"},
                             results_seen, want.chan, got.chan, want.period, got.period,
                             want.rpm, got.rpm);
            end
        endfunction

        function int pending();
            return rpm_q.size();
        endfunction
    endclass

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic                      cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    rpm_scoreboard           sb;
    bit                      steady    = 1'b0;
    int                      hold_left = 0;
    int                      cycles    = 0;
    int                      words_sent = 0;
    int                      settings  = 0;
    logic [CAPTURE_BITS-1:0] sent_cap [NUM_CHANNELS] = '{default: '0};

    tachometer_period_to_rpm DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // channel, capture_time
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // out_channel, period_ticks, rpm
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("** tachometer_period_to_rpm: FAILED **");
            $finish;
        end
    end

    // watch both word handshakes and register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                sb.write_reg(cfg_addr, cfg_wdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_capture(s_tdata[0], s_tdata[CAPTURE_BITS:1]);
        end
    end

    // result side: random stalls, a quiet phase, and a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic send_word(input logic [CHAN_BITS-1:0] ch,
                             input logic [CAPTURE_BITS-1:0] cap);
        int gap;
        if (!steady && $urandom_range(0, 99) < 15) begin
            gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 45 : 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_BITS-IN_FIELD_BITS){1'b0}}, cap, ch};
        do @(posedge aclk); while (!s_tready);
        sent_cap[ch] = cap;
        words_sent++;
    endtask

    // let the last accepted word reach the monitor before polling the scoreboard
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // unused upper bits of the edges-per-revolution write carry noise
    task automatic set_regs(input logic [CLK_HZ_BITS-1:0] clk_hz,
                            input logic [PPR_BITS-1:0] ppr);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_CLOCK_HZ;
        cfg_wdata <= clk_hz;
        @(posedge aclk);
        cfg_addr  <= REG_PPR;
        cfg_wdata <= {(CFG_DATA_BITS-PPR_BITS)'($urandom), ppr};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // mostly plausible edge trains per channel, the rest arbitrary captures
    task automatic random_word();
        logic [CHAN_BITS-1:0]    ch;
        logic [CAPTURE_BITS-1:0] delta;
        logic [CAPTURE_BITS-1:0] cap;
        int                      pick;
        ch   = CHAN_BITS'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 40)
            delta = $urandom_range(1, 2000);
        else if (pick < 60)
            delta = $urandom_range(1, 1 << 20);
        else if (pick < 72)
            delta = $urandom;
        else
            delta = '0;
        cap = (pick < 80) ? sent_cap[ch] + delta : CAPTURE_BITS'($urandom);
        send_word(ch, cap);
    endtask

    initial begin
        logic [CLK_HZ_BITS-1:0] phase_clk [7];
        logic [PPR_BITS-1:0]    phase_ppr [7];
        sb = new();
        phase_clk = '{27'd100000000, 27'd1, 27'h7FF_FFFF, CLK_HZ_BITS'($urandom), 27'd0,
                      CLK_HZ_BITS'($urandom), CLK_HZ_BITS'($urandom_range(1000, 50000000))};
        phase_ppr = '{5'd16, 5'd1, 5'd1, PPR_BITS'($urandom), 5'd7, 5'd0,
                      PPR_BITS'($urandom_range(1, 16))};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values: first edge from zero, zero period, timer wrap
        send_word(1'b0, 32'h0000_0000);
        send_word(1'b1, 32'hFFFF_FFFF);
        send_word(1'b1, 32'h0000_0004);
        send_word(1'b0, 32'h0000_0001);
        send_word(1'b0, 32'h0000_0001);
        send_word(1'b0, 32'h8000_0001);
        send_word(1'b1, 32'h7FFF_FFFF);
        send_word(1'b0, 32'h8000_0003);
        drain();
        set_regs(27'h7FF_FFFF, 5'd16);
        send_word(1'b0, sent_cap[0] + 1);
        send_word(1'b1, sent_cap[1] + 1);
        drain();
        // largest rpm the block can produce
        set_regs(27'h7FF_FFFF, 5'd1);
        send_word(1'b0, sent_cap[0] + 1);
        send_word(1'b1, sent_cap[1] + 3);
        drain();
        set_regs(27'd0, 5'd5);
        send_word(1'b0, sent_cap[0] + 10);
        drain();
        // zero edges per revolution gives a zero divisor
        set_regs(27'd1000, 5'd0);
        send_word(1'b1, sent_cap[1] + 7);
        drain();
        set_regs(27'd1, 5'd31);
        send_word(1'b0, sent_cap[0] + 1);
        send_word(1'b0, sent_cap[0] + 61);
        drain();
        set_regs(27'd100000000, 5'd16);
        send_word(1'b1, sent_cap[1] + 32'hAAAA_AAAA);
        send_word(1'b1, sent_cap[1] + 32'h5555_5555);

        for (int p = 0; p < 7; p++) begin
            drain();
            set_regs(phase_clk[p], phase_ppr[p]);
            steady = (p == 2);
            if (p == 1)
                hold_left = HOLD_CYCLES;
            for (int i = 0; i < PHASE_WORDS; i++)
                random_word();
        end
        steady = 1'b0;
        drain();

        $display("covered %0d capture words over %0d register settings, %0d results checked",
                 words_sent, settings, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** tachometer_period_to_rpm: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
            $display("** tachometer_period_to_rpm: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
rtl/core/tach_pkg.sv
rtl/core/tach_ctrl.sv
rtl/core/tach_dp.sv
rtl/core/tachometer_period_to_rpm.sv
tb/tb_tachometer_period_to_rpm.sv
